>>> hw/rtl/vrt_pkg.sv
// Shared types and constants of the voxel ray traversal and edit block.
`timescale 1ns / 1ps
`default_nettype none
package vrt_pkg;

  localparam int VRT_GRID_X = 32;
  localparam int VRT_GRID_Y = 32;
  localparam int VRT_GRID_Z = 32;

  // Store address is x,y,z with five bits each
  localparam int VRT_COORD_W = 5;
  localparam int VRT_ADDR_W  = 3 * VRT_COORD_W;
  localparam int VRT_DEPTH   = 1 << VRT_ADDR_W;
  localparam int VRT_TYPE_W  = 4;

  localparam int VRT_POS_W   = 17;   // eye position, unsigned Q.10
  localparam int VRT_CELL_W  = 9;    // signed cell index during traversal
  localparam int VRT_RCP_W   = 29;   // floor(2^28 / |d|)
  localparam int VRT_T_W     = 48;   // crossing parameter, Q.24
  localparam int VRT_DT_W    = VRT_RCP_W + 10;
  localparam int VRT_STEP_W  = 7;
  localparam int VRT_EYE_W   = 12;

  localparam logic [VRT_T_W-1:0] VRT_T_MAX = {VRT_T_W{1'b1}};
  localparam logic [VRT_STEP_W-1:0] VRT_STEPS_RST = 7'd25;
  localparam logic [VRT_EYE_W-1:0]  VRT_EYE_RST   = 12'd1638;

  localparam logic [VRT_TYPE_W-1:0] VRT_AIR   = 4'd0;
  localparam logic [VRT_TYPE_W-1:0] VRT_WATER = 4'd7;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_AIM   = 2'd1,
    MODE_BREAK = 2'd2,
    MODE_PLACE = 2'd3
  } vrt_mode_t;

  typedef enum logic [0:0] {
    CFG_MAX_STEPS  = 1'b0,
    CFG_EYE_HEIGHT = 1'b1
  } vrt_cfg_idx_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;
    logic clr_step;
    logic div_step;
    logic setup_step;
    logic rd_cur;
    logic eval_step;
    logic rec_hit;
    logic wr_load;
    logic wr_break;
    logic rd_bef;
    logic wr_place;
    logic out_load;
  } vrt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic      clr_last;
    logic      div_last;
    logic      setup_last;
    logic      steps_left;
    logic      hit_now;
    vrt_mode_t mode;
  } vrt_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/vrt_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module vrt_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/vrt_div.sv
// Bit-serial reciprocal unit: floor(2^28 / divisor), one quotient bit a cycle while step is high.
`timescale 1ns / 1ps
`default_nettype none
module vrt_div
  import vrt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 clr,
  input  wire logic                 step,
  input  wire logic [15:0]          divisor,
  output logic                      done,
  output logic [VRT_RCP_W-1:0]      quot_nxt
);

  localparam int CNT_W = $clog2(VRT_RCP_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VRT_RCP_W - 1);

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [15:0]          rem_r, rem_nxt;
  logic [VRT_RCP_W-1:0] quot_r;
  logic [16:0]          trial;
  logic                 first;

  // Dividend is a single one in its top bit, taken on the first cycle
  always_comb begin
    first = (cnt_r == '0);
    trial = first ? 17'd1 : {rem_r, 1'b0};
    if (trial >= {1'b0, divisor}) begin
      rem_nxt  = 16'(trial - {1'b0, divisor});
      quot_nxt = {quot_r[VRT_RCP_W-2:0], 1'b1};
    end else begin
      rem_nxt  = trial[15:0];
      quot_nxt = {quot_r[VRT_RCP_W-2:0], 1'b0};
    end
    done    = step && (cnt_r == CNT_LAST);
    cnt_nxt = done ? '0 : cnt_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/vrt_datapath.sv
// Datapath: request registers, reciprocal setup, DDA stepping, voxel store, result register.
`timescale 1ns / 1ps
`default_nettype none
module vrt_datapath
  import vrt_pkg::*;
#(
  parameter int GRID_X = VRT_GRID_X,
  parameter int GRID_Y = VRT_GRID_Y,
  parameter int GRID_Z = VRT_GRID_Z
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [11:0]  cfg_wdata,
  input  wire logic [111:0] in_tdata,
  input  wire logic [1:0]   in_tuser,
  input  wire vrt_cmd_t     cmd,
  output vrt_sts_t          sts,
  output logic [47:0]       out_tdata,
  output logic [0:0]        out_tuser
);

  localparam logic signed [VRT_CELL_W-1:0] GX = VRT_CELL_W'(GRID_X);
  localparam logic signed [VRT_CELL_W-1:0] GY = VRT_CELL_W'(GRID_Y);
  localparam logic signed [VRT_CELL_W-1:0] GZ = VRT_CELL_W'(GRID_Z);

  // Configuration
  logic [VRT_STEP_W-1:0] max_steps_r;
  logic [VRT_EYE_W-1:0]  eye_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_steps_r <= VRT_STEPS_RST;
      eye_r       <= VRT_EYE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_STEPS:  max_steps_r <= cfg_wdata[VRT_STEP_W-1:0];
        CFG_EYE_HEIGHT: eye_r       <= cfg_wdata[VRT_EYE_W-1:0];
        default: ;
      endcase
    end
  end

  // Request registers
  vrt_mode_t               mode_r;
  logic [VRT_TYPE_W-1:0]   btype_r;
  logic [VRT_COORD_W-1:0]  ld_r [3];
  logic [14:0]             foot_r [3];
  logic [VRT_POS_W-1:0]    pos_r [3];
  logic signed [15:0]      dir_r [3];

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r    <= vrt_mode_t'(in_tuser);
      ld_r[0]   <= in_tdata[4:0];
      ld_r[1]   <= in_tdata[9:5];
      ld_r[2]   <= in_tdata[14:10];
      btype_r   <= in_tdata[18:15];
      foot_r[0] <= in_tdata[33:19];
      foot_r[1] <= in_tdata[48:34];
      foot_r[2] <= in_tdata[63:49];
      pos_r[0]  <= {2'b00, in_tdata[33:19]};
      pos_r[1]  <= {2'b00, in_tdata[48:34]} + {5'b0, eye_r};
      pos_r[2]  <= {2'b00, in_tdata[63:49]};
      dir_r[0]  <= in_tdata[79:64];
      dir_r[1]  <= in_tdata[95:80];
      dir_r[2]  <= in_tdata[111:96];
    end
  end

  // Axis sequencing for reciprocal and setup
  logic [1:0]           ax_r;
  logic                 div_done;
  logic [VRT_RCP_W-1:0] quot_nxt;
  logic [VRT_RCP_W-1:0] rcp_r [3];
  logic signed [15:0]   dsel;
  logic [15:0]          mag;

  always_comb begin
    dsel = dir_r[ax_r];
    mag  = dsel[15] ? 16'(-dsel) : 16'(dsel);
  end

  vrt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (cmd.latch),
    .step     (cmd.div_step),
    .divisor  (mag),
    .done     (div_done),
    .quot_nxt (quot_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.latch) begin
      ax_r <= '0;
    end else if (div_done || cmd.setup_step) begin
      ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      rcp_r[ax_r] <= quot_nxt;
    end
  end

  // Start parameter: distance to next boundary times reciprocal
  logic [9:0]          frac;
  logic [10:0]         bnd_dist;
  logic                dpos;
  logic [39:0]         prod;

  always_comb begin
    frac     = pos_r[ax_r][9:0];
    dpos     = !dsel[15] && (dsel != 16'sd0);
    bnd_dist = dpos ? 11'(11'd1024 - {1'b0, frac}) : {1'b0, frac};
    prod     = bnd_dist * rcp_r[ax_r];
  end

  // Traversal state
  logic signed [VRT_CELL_W-1:0] cell_r [3];
  logic signed [VRT_CELL_W-1:0] bcell_r [3];
  logic [VRT_T_W-1:0]           t_r [3];
  logic [VRT_DT_W-1:0]          dt_r [3];
  logic                         neg_r [3];
  logic [VRT_STEP_W-1:0]        k_r;
  logic                         hit_r;
  logic [VRT_TYPE_W-1:0]        htype_r;
  logic                         chg_r;

  // Axis choice: x only if strictly smallest, then y below z, else z
  logic [1:0]         sel;
  logic [VRT_T_W:0]   tsum;
  logic [VRT_T_W-1:0] tsat;

  always_comb begin
    if (t_r[0] < t_r[1] && t_r[0] < t_r[2]) begin
      sel = 2'd0;
    end else if (t_r[1] < t_r[2]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
    tsum = {1'b0, t_r[sel]} + (VRT_T_W + 1)'(dt_r[sel]);
    tsat = tsum[VRT_T_W] ? VRT_T_MAX : tsum[VRT_T_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.setup_step) begin
      cell_r[ax_r]  <= VRT_CELL_W'(pos_r[ax_r][VRT_POS_W-1:10]);
      bcell_r[ax_r] <= VRT_CELL_W'(pos_r[ax_r][VRT_POS_W-1:10]);
      neg_r[ax_r]   <= !dpos;
      if (dsel == 16'sd0) begin
        t_r[ax_r]  <= VRT_T_MAX;
        dt_r[ax_r] <= '0;
      end else begin
        t_r[ax_r]  <= VRT_T_W'(prod);
        dt_r[ax_r] <= {rcp_r[ax_r], 10'd0};
      end
    end else if (cmd.eval_step) begin
      for (int a = 0; a < 3; a++) begin
        bcell_r[a] <= cell_r[a];
      end
      cell_r[sel] <= neg_r[sel] ? cell_r[sel] - VRT_CELL_W'(1)
                                : cell_r[sel] + VRT_CELL_W'(1);
      t_r[sel]    <= tsat;
    end
  end

  // Bounds tests
  logic cur_in, bef_in, load_in;

  always_comb begin
    cur_in  = !cell_r[0][VRT_CELL_W-1] && cell_r[0] < GX &&
              !cell_r[1][VRT_CELL_W-1] && cell_r[1] < GY &&
              !cell_r[2][VRT_CELL_W-1] && cell_r[2] < GZ;
    bef_in  = !bcell_r[0][VRT_CELL_W-1] && bcell_r[0] < GX &&
              !bcell_r[1][VRT_CELL_W-1] && bcell_r[1] < GY &&
              !bcell_r[2][VRT_CELL_W-1] && bcell_r[2] < GZ;
    load_in = VRT_CELL_W'(ld_r[0]) < GX && VRT_CELL_W'(ld_r[1]) < GY &&
              VRT_CELL_W'(ld_r[2]) < GZ;
  end

  // Player box clearance of the before cell
  logic signed [17:0] dpx, dpy, dpz, apx, apz;
  logic               box_free;

  always_comb begin
    dpx = $signed({3'b0, bcell_r[0][4:0], 10'd512}) - $signed({3'b0, foot_r[0]});
    dpy = $signed({3'b0, bcell_r[1][4:0], 10'd0})   - $signed({3'b0, foot_r[1]});
    dpz = $signed({3'b0, bcell_r[2][4:0], 10'd512}) - $signed({3'b0, foot_r[2]});
    apx = dpx[17] ? -dpx : dpx;
    apz = dpz[17] ? -dpz : dpz;
    box_free = apx >= 18'sd410 || apz >= 18'sd410 ||
               dpy >= 18'sd1946 || dpy <= -18'sd103;
  end

  // Voxel store port selection
  logic [VRT_ADDR_W-1:0]   clr_cnt_r;
  logic                    ram_we;
  logic [VRT_ADDR_W-1:0]   ram_waddr, ram_raddr, cur_addr, bef_addr;
  logic [VRT_TYPE_W-1:0]   ram_wdata, ram_rdata;
  logic                    solid, place_ok, load_wr;

  always_comb begin
    cur_addr = {cell_r[0][4:0], cell_r[1][4:0], cell_r[2][4:0]};
    bef_addr = {bcell_r[0][4:0], bcell_r[1][4:0], bcell_r[2][4:0]};
    solid    = cur_in && ram_rdata != VRT_AIR && ram_rdata != VRT_WATER;
    place_ok = bef_in && ram_rdata == VRT_AIR && box_free;
    load_wr  = cmd.wr_load && load_in;
    ram_raddr = cmd.rd_bef ? bef_addr : cur_addr;
    ram_we    = cmd.clr_step || load_wr || cmd.wr_break || (cmd.wr_place && place_ok);
    if (cmd.clr_step) begin
      ram_waddr = clr_cnt_r;
      ram_wdata = VRT_AIR;
    end else if (cmd.wr_load) begin
      ram_waddr = {ld_r[0], ld_r[1], ld_r[2]};
      ram_wdata = btype_r;
    end else if (cmd.wr_break) begin
      ram_waddr = cur_addr;
      ram_wdata = VRT_AIR;
    end else begin
      ram_waddr = bef_addr;
      ram_wdata = btype_r;
    end
  end

  vrt_ram #(.WIDTH(VRT_TYPE_W), .DEPTH(VRT_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + VRT_ADDR_W'(1);
    end
  end

  // Step count, hit and change flags
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.latch) begin
      k_r   <= '0;
      hit_r <= 1'b0;
      chg_r <= 1'b0;
    end else begin
      if (cmd.eval_step) begin
        k_r <= k_r + VRT_STEP_W'(1);
      end
      if (cmd.rec_hit) begin
        hit_r <= 1'b1;
      end
      if (ram_we && !cmd.clr_step) begin
        chg_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rec_hit) begin
      htype_r <= ram_rdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tuser[0] <= hit_r;
      if (hit_r) begin
        out_tdata[4:0]   <= cell_r[0][4:0];
        out_tdata[9:5]   <= cell_r[1][4:0];
        out_tdata[14:10] <= cell_r[2][4:0];
        out_tdata[21:15] <= bcell_r[0][6:0];
        out_tdata[28:22] <= bcell_r[1][6:0];
        out_tdata[35:29] <= bcell_r[2][6:0];
        out_tdata[39:36] <= htype_r;
      end else begin
        out_tdata[39:0] <= '0;
      end
      out_tdata[40]    <= chg_r;
      out_tdata[47:41] <= '0;
    end
  end

  always_comb begin
    sts.clr_last   = (clr_cnt_r == {VRT_ADDR_W{1'b1}});
    sts.div_last   = div_done && (ax_r == 2'd2);
    sts.setup_last = (ax_r == 2'd2);
    sts.steps_left = (k_r < max_steps_r);
    sts.hit_now    = solid;
    sts.mode       = mode_r;
  end

endmodule
`default_nettype wire

>>> hw/rtl/vrt_ctrl.sv
// Controller: sequences clearing, setup, traversal, edits and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module vrt_ctrl
  import vrt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  input  wire vrt_sts_t sts,
  output vrt_cmd_t      cmd
);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_LOAD   = 11'b00000000100,
    S_DIV    = 11'b00000001000,
    S_SETUP  = 11'b00000010000,
    S_CHECK  = 11'b00000100000,
    S_EVAL   = 11'b00001000000,
    S_POST   = 11'b00010000000,
    S_PLACE  = 11'b00100000000,
    S_FINISH = 11'b01000000000,
    S_SPARE  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    slot_free = !out_valid_r || out_tready;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // Load requests skip the ray entirely
        if (sts.mode == MODE_LOAD) begin
          state_nxt = S_LOAD;
        end else begin
          cmd.div_step = 1'b1;
          if (sts.div_last) state_nxt = S_SETUP;
        end
      end
      S_LOAD: begin
        cmd.wr_load = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_SETUP: begin
        cmd.setup_step = 1'b1;
        if (sts.setup_last) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.steps_left) begin
          cmd.rd_cur = 1'b1;
          state_nxt  = S_EVAL;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_EVAL: begin
        if (sts.hit_now) begin
          cmd.rec_hit = 1'b1;
          state_nxt   = S_POST;
        end else begin
          cmd.eval_step = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_POST: begin
        case (sts.mode)
          MODE_BREAK: begin
            cmd.wr_break = 1'b1;
            state_nxt    = S_FINISH;
          end
          MODE_PLACE: begin
            cmd.rd_bef = 1'b1;
            state_nxt  = S_PLACE;
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_PLACE: begin
        cmd.wr_place = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

>>> hw/rtl/voxel_ray_traversal_edit_core.sv
// Top level of the voxel ray traversal and edit block.
//
//  channel | direction | handshake           | payload
//  in_     | slave     | in_tvalid/in_tready | in_tdata 112b, in_tuser mode
//  out_    | master    | out_tvalid/tready   | out_tdata 48b, out_tuser hit
//  cfg_    | write     | cfg_we              | cfg_index, cfg_wdata 12b
//
// After reset the voxel store is swept to air with in_tready low.
// A load passes through S_DIV, S_LOAD and S_FINISH. A ray runs the serial reciprocal
// per axis (one quotient bit per cycle), a setup step per axis, a check and an
// evaluation per cell (registered store read), on a hit the edit states, and the hand-off.
// One request is worked at a time; the result register frees the input while a
// result waits, and a stalled output only holds the block in its hand-off cycle.
`timescale 1ns / 1ps
`default_nettype none
module voxel_ray_traversal_edit_core
  import vrt_pkg::*;
#(
  parameter int GRID_X = VRT_GRID_X,
  parameter int GRID_Y = VRT_GRID_Y,
  parameter int GRID_Z = VRT_GRID_Z
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [11:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // load_x, load_y, load_z, block_type, foot_x, foot_y, foot_z, dir_x, dir_y, dir_z
  input  wire logic [111:0] in_tdata,
  // mode
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // hit_x, hit_y, hit_z, before_x, before_y, before_z, hit_type, changed, zero pad
  output logic [47:0]       out_tdata,
  // hit
  output logic [0:0]        out_tuser
);

  vrt_cmd_t cmd;
  vrt_sts_t sts;

  vrt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  vrt_datapath #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
`default_nettype wire

>>> hw/rtl/vrt_checker.sv
// Port-level checks of the voxel ray traversal block and their binding.
`timescale 1ns / 1ps
`default_nettype none
module vrt_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [47:0]  out_tdata,
  input wire logic [0:0]   out_tuser
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Reset starts the clearing sweep with input closed
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input open during store clear");

  // One request in flight
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  // Miss reports zero cells and type
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[39:0] == 40'd0)
    else $error("miss with nonzero cell fields");

endmodule

bind voxel_ray_traversal_edit_core vrt_checker u_vrt_checker (.*);
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the voxel ray traversal and edit core.
`timescale 1ns / 1ps
module tb_top;
  import vrt_pkg::*;

  localparam longint unsigned T_SAT = (64'd1 << 48) - 64'd1;

  typedef struct {
    vrt_mode_t          mode;
    logic [4:0]         lx, ly, lz;
    logic [3:0]         btype;
    logic [14:0]        fx, fy, fz;
    logic signed [15:0] dx, dy, dz;
  } ray_req_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] hx, hy, hz;
    logic [6:0] bx, by, bz;
    logic [3:0] htype;
    logic       changed;
  } ray_res_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_we = 1'b0;
  logic          cfg_index = CFG_MAX_STEPS;
  logic [11:0]   cfg_wdata = '0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [111:0]  in_tdata = '0;
  logic [1:0]    in_tuser = MODE_LOAD;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [47:0]   out_tdata;
  logic [0:0]    out_tuser;

  // Shadow of the block: voxel store and registers
  logic [3:0]    shadow_map [0:32767];
  int unsigned   steps_reg;
  int unsigned   eye_reg;

  ray_res_t      pending_q [$];
  int            errors = 0;
  int            n_items = 0;
  int            n_hits = 0;
  int            n_changed = 0;
  int            n_results = 0;
  bit            burst = 1'b0;
  int            out_hold = 0;

  voxel_ray_traversal_edit_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #4 clk = ~clk;

  function automatic bit cell_inside(int x, int y, int z);
    return x >= 0 && x < VRT_GRID_X && y >= 0 && y < VRT_GRID_Y && z >= 0 && z < VRT_GRID_Z;
  endfunction

  function automatic int unsigned cell_addr(int x, int y, int z);
    return ((x & 31) << 10) | ((y & 31) << 5) | (z & 31);
  endfunction

  function automatic longint unsigned t_add(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > T_SAT) ? T_SAT : s;
  endfunction

  // Start cell, step and crossing parameters for one axis
  function automatic void axis_init(input int unsigned pos, input int d, output int cell_o,
                                    output int stp, output longint unsigned t,
                                    output longint unsigned dt);
    int unsigned frac;
    longint unsigned bnd_dist;
    longint unsigned r;
    frac = pos & 1023;
    cell_o = int'(pos >> 10);
    if (d > 0) begin
      stp = 1;
      bnd_dist = 1024 - frac;
    end else begin
      stp = -1;
      bnd_dist = frac;
    end
    if (d == 0) begin
      t = T_SAT;
      dt = 0;
    end else begin
      r = (64'd1 << 28) / longint'((d < 0) ? -d : d);
      t = bnd_dist * r;
      dt = r << 10;
    end
  endfunction

  // Work out the result of one request and apply its edit to the shadow store
  function automatic ray_res_t trace_and_edit(ray_req_t q);
    ray_res_t res;
    int ix, iy, iz, sx, sy, sz, bx, by, bz;
    int dpx, dpy, dpz;
    longint unsigned tx, ty, tz, dtx, dty, dtz;
    logic [3:0] v;
    bit found;
    res = '0;
    found = 1'b0;
    if (q.mode == MODE_LOAD) begin
      if (cell_inside(q.lx, q.ly, q.lz)) begin
        shadow_map[cell_addr(q.lx, q.ly, q.lz)] = q.btype;
        res.changed = 1'b1;
      end
      return res;
    end
    axis_init(q.fx, q.dx, ix, sx, tx, dtx);
    axis_init(q.fy + eye_reg, q.dy, iy, sy, ty, dty);
    axis_init(q.fz, q.dz, iz, sz, tz, dtz);
    bx = ix; by = iy; bz = iz;
    for (int k = 0; k < steps_reg; k++) begin
      if (cell_inside(ix, iy, iz)) begin
        v = shadow_map[cell_addr(ix, iy, iz)];
        if (v != VRT_AIR && v != VRT_WATER) begin
          found = 1'b1;
          res.htype = v;
          break;
        end
      end
      bx = ix; by = iy; bz = iz;
      if (tx < ty && tx < tz) begin
        ix += sx; tx = t_add(tx, dtx);
      end else if (ty < tz) begin
        iy += sy; ty = t_add(ty, dty);
      end else begin
        iz += sz; tz = t_add(tz, dtz);
      end
    end
    if (!found) return res;
    res.hit = 1'b1;
    res.hx = ix[4:0]; res.hy = iy[4:0]; res.hz = iz[4:0];
    res.bx = bx[6:0]; res.by = by[6:0]; res.bz = bz[6:0];
    if (q.mode == MODE_BREAK) begin
      shadow_map[cell_addr(ix, iy, iz)] = VRT_AIR;
      res.changed = 1'b1;
    end else if (q.mode == MODE_PLACE) begin
      if (cell_inside(bx, by, bz) && shadow_map[cell_addr(bx, by, bz)] == VRT_AIR) begin
        dpx = bx * 1024 + 512 - int'(q.fx);
        dpy = by * 1024 - int'(q.fy);
        dpz = bz * 1024 + 512 - int'(q.fz);
        if (dpx < 0) dpx = -dpx;
        if (dpz < 0) dpz = -dpz;
        if (dpx * 10 > 4096 || dpy * 10 > 19456 || dpy * 10 < -1024 || dpz * 10 > 4096) begin
          shadow_map[cell_addr(bx, by, bz)] = q.btype;
          res.changed = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // Drive one request, wait for its acceptance, record its expected result
  task automatic send_request(ray_req_t q);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= q.mode;
    in_tdata  <= {q.dz, q.dy, q.dx, q.fz, q.fy, q.fx, q.btype, q.lz, q.ly, q.lx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_q.push_back(trace_and_edit(q));
    n_items++;
  endtask

  task automatic load_voxel(int x, int y, int z, int t);
    ray_req_t q;
    q.mode = MODE_LOAD;
    q.lx = x; q.ly = y; q.lz = z; q.btype = t;
    q.fx = $urandom; q.fy = $urandom; q.fz = $urandom;
    q.dx = $urandom; q.dy = $urandom; q.dz = $urandom;
    send_request(q);
  endtask

  task automatic cast_ray(vrt_mode_t m, int t, int fx, int fy, int fz, int dx, int dy, int dz);
    ray_req_t q;
    q.mode = m;
    q.lx = $urandom; q.ly = $urandom; q.lz = $urandom; q.btype = t;
    q.fx = fx; q.fy = fy; q.fz = fz;
    q.dx = dx; q.dy = dy; q.dz = dz;
    send_request(q);
  endtask

  // Wait until the block is idle, then write one register
  task automatic write_reg(vrt_cfg_idx_t idx, int value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 12'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_STEPS) steps_reg = value & 7'h7F;
    else eye_reg = value & 12'hFFF;
  endtask

  // Accept results with random stalls and check each one
  always @(posedge clk) begin
    ray_res_t got;
    ray_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.hit = out_tuser[0];
      got.hx = out_tdata[4:0];   got.hy = out_tdata[9:5];   got.hz = out_tdata[14:10];
      got.bx = out_tdata[21:15]; got.by = out_tdata[28:22]; got.bz = out_tdata[35:29];
      got.htype = out_tdata[39:36];
      got.changed = out_tdata[40];
      n_results++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result hit=%0d tdata=%h", got.hit, out_tdata);
      end else begin
        want = pending_q.pop_front();
        if (want.hit) n_hits++;
        if (want.changed) n_changed++;
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("result %0d: exp hit=%0d hit=%0d,%0d,%0d bef=%0d,%0d,%0d t=%0d ch=%0d | got hit=%0d hit=%0d,%0d,%0d bef=%0d,%0d,%0d t=%0d ch=%0d",
                     n_results, want.hit, want.hx, want.hy, want.hz,
                     $signed(want.bx), $signed(want.by), $signed(want.bz),
                     want.htype, want.changed,
                     got.hit, got.hx, got.hy, got.hz,
                     $signed(got.bx), $signed(got.by), $signed(got.bz),
                     got.htype, got.changed);
        end
      end
      out_hold = burst ? 0 : $urandom_range(0, 15);
      out_tready <= (out_hold == 0);
    end else if (out_hold > 0) begin
      out_hold--;
      out_tready <= (out_hold == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Known scenes along the axes: first-check hits, water, break, place and its refusals
  task automatic test_directed();
    int c;
    c = 16 * 1024 + 512;
    cast_ray(MODE_AIM, 0, c, 15258, c, 16384, 0, 0);
    cast_ray(MODE_AIM, 0, 5 * 1024, 15258, 10 * 1024 + 3, 0, 0, 0);
    load_voxel(16, 16, 16, 3);
    cast_ray(MODE_PLACE, 4, c, 15258, c, -16384, 16384, 0);
    cast_ray(MODE_PLACE, 5, 10 * 1024 + 512, 15258, c, 16384, 0, 0);
    cast_ray(MODE_AIM, 0, 10 * 1024 + 512, 15258, c, 16384, 0, 0);
    cast_ray(MODE_BREAK, 0, 10 * 1024 + 512, 15258, c, 16384, 0, 0);
    cast_ray(MODE_PLACE, 6, 15 * 1024 + 512, 15258, c, 16384, 0, 0);
    load_voxel(20, 16, 16, 7);
    load_voxel(22, 16, 16, 8);
    cast_ray(MODE_PLACE, 0, 18 * 1024 + 512, 15258, c, 16384, 0, 0);
    cast_ray(MODE_AIM, 0, 18 * 1024 + 512, 15258, c, 16384, 0, 0);
    cast_ray(MODE_PLACE, 9, c, 32767, c, 0, -16384, 0);
    load_voxel(10, 31, 10, 12);
    cast_ray(MODE_PLACE, 2, 10 * 1024 + 512, 32767, 10 * 1024 + 512, 0, -16384, 0);
    cast_ray(MODE_BREAK, 0, 10 * 1024 + 512, 32767, 10 * 1024 + 512, 0, -16384, 0);
    load_voxel(31, 31, 31, 15);
    cast_ray(MODE_AIM, 0, 31 * 1024 + 512, 30618, 28 * 1024 + 512, 0, 0, 16384);
    load_voxel(0, 0, 0, 1);
    cast_ray(MODE_BREAK, 0, 32767, 32767, 32767, -16384, -16384, -16384);
    cast_ray(MODE_AIM, 0, 0, 0, 0, 1, -1, 1);
    cast_ray(MODE_AIM, 0, 2000, 0, 1500, -16384, -1, -16384);
  endtask

  // Register extremes: a one-cell ray, the longest ray, eye at feet and at its top
  task automatic test_config_extremes();
    write_reg(CFG_MAX_STEPS, 1);
    write_reg(CFG_EYE_HEIGHT, 0);
    cast_ray(MODE_AIM, 0, 22 * 1024 + 100, 16 * 1024 + 7, 16 * 1024 + 512, 16384, 0, 0);
    cast_ray(MODE_AIM, 0, 22 * 1024 + 100, 16 * 1024 + 7, 16 * 1024 + 512, 0, 0, 0);
    write_reg(CFG_MAX_STEPS, 127);
    write_reg(CFG_EYE_HEIGHT, 4095);
    cast_ray(MODE_AIM, 0, 100, 100, 100, 16384, 8000, 16384);
    cast_ray(MODE_PLACE, 8, 3 * 1024 + 9, 12 * 1024, 16 * 1024 + 512, 16384, 0, 0);
    write_reg(CFG_MAX_STEPS, 25);
    write_reg(CFG_EYE_HEIGHT, 1638);
  endtask

  function automatic int rand_dir();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 20) return 16384;
    if (r < 25) return -16384;
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  function automatic int rand_pos();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 32767);
    return $urandom_range(6 * 1024, 26 * 1024 - 1);
  endfunction

  function automatic int rand_cell();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 31);
    return $urandom_range(10, 21);
  endfunction

  function automatic int rand_type();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(1, 8);
    if (r < 8) return 0;
    if (r < 9) return 7;
    return $urandom_range(9, 15);
  endfunction

  // Mostly rays through a dense cluster, with loads keeping it populated
  task automatic test_random_traffic(int n_req);
    for (int i = 0; i < n_req; i++) begin
      if ($urandom_range(0, 3) == 0)
        load_voxel(rand_cell(), rand_cell(), rand_cell(), rand_type());
      else
        cast_ray(vrt_mode_t'($urandom_range(1, 3)), $urandom_range(0, 15),
                 rand_pos(), rand_pos(), rand_pos(), rand_dir(), rand_dir(), rand_dir());
    end
  endtask

  // Fill the cluster so that random rays find solid cells
  task automatic test_fill_cluster(int n_req);
    for (int i = 0; i < n_req; i++)
      load_voxel($urandom_range(10, 21), $urandom_range(10, 21), $urandom_range(10, 21),
                 rand_type());
  endtask

  initial begin
    foreach (shadow_map[i]) shadow_map[i] = VRT_AIR;
    steps_reg = VRT_STEPS_RST;
    eye_reg = VRT_EYE_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_config_extremes();
    burst = 1'b1;
    test_fill_cluster(300);
    burst = 1'b0;
    test_random_traffic(300);
    write_reg(CFG_MAX_STEPS, 127);
    write_reg(CFG_EYE_HEIGHT, 4095);
    burst = 1'b1;
    test_random_traffic(250);
    burst = 1'b0;
    write_reg(CFG_MAX_STEPS, 1);
    write_reg(CFG_EYE_HEIGHT, 0);
    test_random_traffic(250);
    write_reg(CFG_MAX_STEPS, $urandom_range(1, 127));
    write_reg(CFG_EYE_HEIGHT, $urandom_range(0, 4095));
    test_random_traffic(300);
    write_reg(CFG_MAX_STEPS, 40);
    write_reg(CFG_EYE_HEIGHT, 1638);
    test_random_traffic(250);

    // Drain outstanding results, then allow the latency of one long ray
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("covered %0d requests, %0d results: %0d hits, %0d store writes",
             n_items, n_results, n_hits, n_changed);
    $display("register settings swept from one to 127 steps and eye offsets 0 to 4095");
    if (errors == 0) begin
      $display("voxel_ray_traversal_edit_core: match");
    end else begin
      $display("voxel_ray_traversal_edit_core: mismatch");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #40000000;
    $display("voxel_ray_traversal_edit_core: mismatch");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/vrt_pkg.sv
hw/rtl/vrt_ram.sv
hw/rtl/vrt_div.sv
hw/rtl/vrt_datapath.sv
hw/rtl/vrt_ctrl.sv
hw/rtl/voxel_ray_traversal_edit_core.sv
hw/rtl/vrt_checker.sv
bench/tb_top.sv
